/* hw/rtl/rrf_pkg.sv */
package rrf_pkg;

    // Fixed field widths of the register map and the request channels.
    localparam int COORD_W    = 12;
    localparam int POS_W      = 16;
    localparam int SIDE_CFG_W = 13;
    localparam int RADIUS_W   = 12;
    localparam int CFG_DATA_W = 16;

    // Largest side honoured; wider rectangles saturate to this.
    localparam int MAX_SIDE  = 4096;
    localparam int ADDR_BITS = 24;

    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int GEO_BASE = (SIDE_W > COORD_W + 1) ? SIDE_W : COORD_W + 1;
    localparam int GEO_W    = GEO_BASE + 1;
    localparam int SQ_W     = 2 * GEO_W;
    localparam int PROD_W   = POS_W + SIDE_CFG_W;

    typedef enum logic [2:0] {
        CFG_RECT_X,
        CFG_RECT_Y,
        CFG_RECT_W,
        CFG_RECT_H,
        CFG_RADIUS,
        CFG_SURF_W,
        CFG_SURF_H,
        CFG_STRIDE
    } cfg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  rect_x;
        logic signed [POS_W-1:0]  rect_y;
        logic [SIDE_CFG_W-1:0]    rect_w;
        logic [SIDE_CFG_W-1:0]    rect_h;
        logic [RADIUS_W-1:0]      corner_radius;
        logic [SIDE_CFG_W-1:0]    surf_width;
        logic [SIDE_CFG_W-1:0]    surf_height;
        logic [SIDE_CFG_W-1:0]    surf_stride;
    } cfg_t;

    // Partial results handed from the geometry stage to the resolve stage.
    typedef struct packed {
        logic                 in_rect;
        logic                 square;
        logic                 band;
        logic [SQ_W-1:0]      sq_x;
        logic [SQ_W-1:0]      sq_y;
        logic [SQ_W-1:0]      rad_sq;
        logic                 on_surf;
        logic [ADDR_BITS-1:0] row_base;
        logic [ADDR_BITS-1:0] col;
    } geom_t;

endpackage

/* hw/rtl/rrf_pixel_if.sv */
interface rrf_pixel_if import rrf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] local_x;
    logic [COORD_W-1:0] local_y;

    modport source (output valid, output local_x, output local_y, input ready);
    modport sink   (input valid, input local_x, input local_y, output ready);
endinterface

/* hw/rtl/rrf_result_if.sv */
interface rrf_result_if import rrf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 write_pixel;
    logic [ADDR_BITS-1:0] pixel_address;

    modport source (output valid, output write_pixel, output pixel_address, input ready);
    modport sink   (input valid, input write_pixel, input pixel_address, output ready);
endinterface

/* hw/rtl/rrf_cfg_if.sv */
interface rrf_cfg_if import rrf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    cfg_idx_t              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/rounded_rect_fill_pixel.sv */
// Rounded rectangle coverage: each request on the pixel channel names one pixel
// in coordinates local to the configured rectangle, and the block answers with
// exactly one result request carrying a write flag and the linear address
// row * stride + column on the surface. The block takes one pixel every clock
// cycle while the result channel does not stall, and each pixel passes an input
// register, a geometry stage whose squaring and row-address multipliers end in
// a register, and a result register after the distance compare and address
// add. Results leave in the order the pixels arrived. A stalled result
// register freezes the geometry stage at once, so the pixel channel is held
// back as soon as the input register is occupied. The address is zero
// whenever the write flag is low. Registers are written through the
// configuration channel, which is always ready and takes one write per cycle;
// they must only be changed while no pixel is in flight.
module rounded_rect_fill_pixel import rrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rrf_pixel_if.sink    pix,
    rrf_result_if.source res,
    rrf_cfg_if.sink      cfg
);

    cfg_t  cfg_q;
    geom_t mid;
    logic  mid_valid;
    logic  mid_en;

    // Register file for rectangle, radius and surface settings.
    rrf_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // Input register plus the radius clamp, corner distances, surface clip
    // and the multiplications, all closed by the intermediate register.
    rrf_geom u_geom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .local_x   (pix.local_x),
        .local_y   (pix.local_y),
        .cfg       (cfg_q),
        .mid_en    (mid_en),
        .mid_valid (mid_valid),
        .mid       (mid)
    );

    // Distance compare, final write decision and address sum, then the
    // result register that faces the downstream consumer.
    rrf_resolve u_resolve
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mid_valid     (mid_valid),
        .mid           (mid),
        .mid_en        (mid_en),
        .out_valid     (res.valid),
        .out_ready     (res.ready),
        .write_pixel   (res.write_pixel),
        .pixel_address (res.pixel_address)
    );

endmodule

/* hw/rtl/rrf_cfg_regs.sv */
module rrf_cfg_regs import rrf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  cfg_idx_t              wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                CFG_RECT_X: cfg_next.rect_x        = wr_data[POS_W-1:0];
                CFG_RECT_Y: cfg_next.rect_y        = wr_data[POS_W-1:0];
                CFG_RECT_W: cfg_next.rect_w        = wr_data[SIDE_CFG_W-1:0];
                CFG_RECT_H: cfg_next.rect_h        = wr_data[SIDE_CFG_W-1:0];
                CFG_RADIUS: cfg_next.corner_radius = wr_data[RADIUS_W-1:0];
                CFG_SURF_W: cfg_next.surf_width    = wr_data[SIDE_CFG_W-1:0];
                CFG_SURF_H: cfg_next.surf_height   = wr_data[SIDE_CFG_W-1:0];
                CFG_STRIDE: cfg_next.surf_stride   = wr_data[SIDE_CFG_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hw/rtl/rrf_geom.sv */
module rrf_geom import rrf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] local_x,
    input  logic [COORD_W-1:0] local_y,
    input  cfg_t               cfg,
    input  logic               mid_en,
    output logic               mid_valid,
    output geom_t              mid
);

    logic               in_valid_reg;
    logic [COORD_W-1:0] lx_reg;
    logic [COORD_W-1:0] ly_reg;
    logic               mid_valid_reg;
    geom_t              mid_reg;
    geom_t              mid_next;
    logic               in_en;

    logic [GEO_W-1:0]        lx;
    logic [GEO_W-1:0]        ly;
    logic [GEO_W-1:0]        w;
    logic [GEO_W-1:0]        h;
    logic [GEO_W-1:0]        r0;
    logic [GEO_W-1:0]        r_a;
    logic [GEO_W-1:0]        r;
    logic signed [GEO_W:0]   cx;
    logic signed [GEO_W:0]   cy;
    logic signed [GEO_W:0]   ddx;
    logic signed [GEO_W:0]   ddy;
    logic [GEO_W-1:0]        adx;
    logic [GEO_W-1:0]        ady;
    logic                    band_x;
    logic                    band_y;
    logic signed [POS_W:0]   sx;
    logic signed [POS_W:0]   sy;
    logic [PROD_W-1:0]       prod;

    assign in_en     = !in_valid_reg || mid_en;
    assign in_ready  = in_en;
    assign mid_valid = mid_valid_reg;
    assign mid       = mid_reg;

    always_comb
    begin
        lx = GEO_W'(lx_reg);
        ly = GEO_W'(ly_reg);

        if (int'(cfg.rect_w) > MAX_SIDE)
            w = GEO_W'(MAX_SIDE);
        else
            w = GEO_W'(cfg.rect_w);
        if (int'(cfg.rect_h) > MAX_SIDE)
            h = GEO_W'(MAX_SIDE);
        else
            h = GEO_W'(cfg.rect_h);

        // Radius is limited to half the width, then to half the height.
        r0 = GEO_W'(cfg.corner_radius);
        if ((r0 << 1) > w)
            r_a = w >> 1;
        else
            r_a = r0;
        if ((r_a << 1) > h)
            r = h >> 1;
        else
            r = r_a;

        band_x = (lx >= r) && (lx < w - r);
        band_y = (ly >= r) && (ly < h - r);

        cx = (lx < r) ? $signed({1'b0, r}) : $signed({1'b0, w - r - GEO_W'(1)});
        cy = (ly < r) ? $signed({1'b0, r}) : $signed({1'b0, h - r - GEO_W'(1)});
        ddx = $signed({1'b0, lx}) - cx;
        ddy = $signed({1'b0, ly}) - cy;
        adx = ddx[GEO_W] ? GEO_W'(-ddx) : ddx[GEO_W-1:0];
        ady = ddy[GEO_W] ? GEO_W'(-ddy) : ddy[GEO_W-1:0];

        sx = {cfg.rect_x[POS_W-1], cfg.rect_x} + {{(POS_W+1-COORD_W){1'b0}}, lx_reg};
        sy = {cfg.rect_y[POS_W-1], cfg.rect_y} + {{(POS_W+1-COORD_W){1'b0}}, ly_reg};
        prod = PROD_W'(sy[POS_W-1:0]) * PROD_W'(cfg.surf_stride);

        mid_next.in_rect  = (lx < w) && (ly < h);
        mid_next.square   = (cfg.corner_radius == '0);
        mid_next.band     = band_x || band_y;
        mid_next.sq_x     = SQ_W'(adx) * SQ_W'(adx);
        mid_next.sq_y     = SQ_W'(ady) * SQ_W'(ady);
        mid_next.rad_sq   = SQ_W'(r) * SQ_W'(r);
        mid_next.on_surf  = !sx[POS_W] && !sy[POS_W]
                          && (sx[POS_W-1:0] < POS_W'(cfg.surf_width))
                          && (sy[POS_W-1:0] < POS_W'(cfg.surf_height));
        mid_next.row_base = ADDR_BITS'(prod);
        mid_next.col      = ADDR_BITS'(sx[POS_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_en)
                in_valid_reg <= in_valid;
            if (mid_en)
                mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en && in_valid)
        begin
            lx_reg <= local_x;
            ly_reg <= local_y;
        end
        if (mid_en && in_valid_reg)
            mid_reg <= mid_next;
    end

endmodule

/* hw/rtl/rrf_resolve.sv */
module rrf_resolve import rrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mid_valid,
    input  geom_t                mid,
    output logic                 mid_en,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 write_pixel,
    output logic [ADDR_BITS-1:0] pixel_address
);

    logic                 out_valid_reg;
    logic                 write_reg;
    logic                 write_next;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] addr_next;
    logic [SQ_W:0]        dist_sum;
    logic                 covered;
    logic                 out_en;

    assign out_en        = !out_valid_reg || out_ready;
    assign mid_en        = out_en;
    assign out_valid     = out_valid_reg;
    assign write_pixel   = write_reg;
    assign pixel_address = addr_reg;

    always_comb
    begin
        dist_sum   = (SQ_W+1)'(mid.sq_x) + (SQ_W+1)'(mid.sq_y);
        covered    = mid.in_rect
                     && (mid.square || mid.band || dist_sum <= (SQ_W+1)'(mid.rad_sq));
        write_next = covered && mid.on_surf;
        addr_next  = write_next ? mid.row_base + mid.col : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en && mid_valid)
        begin
            write_reg <= write_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

/* hw/rtl/rrf_checker.sv */
module rrf_checker import rrf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 write_pixel,
    input logic [ADDR_BITS-1:0] pixel_address
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(write_pixel) && $stable(pixel_address))
        else $error("result changed while stalled");

    // Unwritten pixels report a zero address.
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_pixel |-> pixel_address == '0)
        else $error("address not zero on unwritten pixel");

    // With the result register empty the whole pipe can move.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output empty");

    // An accepted request passes the input, geometry and result registers and is offered when the consumer keeps up.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing three cycles after request");

endmodule

bind rounded_rect_fill_pixel rrf_checker u_rrf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pix.valid),
    .in_ready      (pix.ready),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .write_pixel   (res.write_pixel),
    .pixel_address (res.pixel_address)
);
